/* hdl/sbm_pkg.sv */
// Shared types and constants for the battery monitor sequencer.
// Used by sbm_ctrl, sbm_datapath and the top level; depends on nothing.
package sbm_pkg;

  // Input action codes.
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_COMPARISONS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STOP_MV          = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_SELECT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_MIN_MV   = 2'd3;

  // Register widths and reset values.
  localparam int MAXC_W   = 12;
  localparam int MV_CFG_W = 14;
  localparam int REFSEL_W = 2;
  localparam logic [MAXC_W-1:0]   MAXC_RESET    = 12'd60;
  localparam logic [MV_CFG_W-1:0] STOP_RESET    = 14'd1550;
  localparam logic [REFSEL_W-1:0] REFSEL_RESET  = 2'd0;
  localparam logic [MV_CFG_W-1:0] BATMIN_RESET  = 14'd1550;

  // Reference selector codes and reference voltages in millivolts.
  localparam logic [REFSEL_W-1:0] REFSEL_1200 = 2'd0;
  localparam logic [REFSEL_W-1:0] REFSEL_1800 = 2'd1;
  localparam logic [REFSEL_W-1:0] REFSEL_2400 = 2'd2;
  localparam int REF_W = 12;
  localparam logic [REF_W-1:0] REF_MV_1200 = 12'd1200;
  localparam logic [REF_W-1:0] REF_MV_1800 = 12'd1800;
  localparam logic [REF_W-1:0] REF_MV_2400 = 12'd2400;

  // Scaling: battery = 4017 * mv / 1000. The divide by 1000 is done as a
  // multiply by ceil(2^34 / 1000) and a shift; exact for products below 2^24.
  localparam int MV_W      = 12;
  localparam int SCALED_W  = 24;
  localparam logic [MV_W-1:0] BATT_SCALE = 12'd4017;
  localparam int RECIP_W   = 25;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_PROD_W = SCALED_W + RECIP_W;
  localparam int BAT_W     = 14;

  // Comparison counter.
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Power source codes.
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_USB  = 2'd1;
  localparam logic [1:0] SRC_BATT = 2'd2;
  localparam logic [1:0] SRC_BOTH = 2'd3;

  // Kinds of result item.
  localparam logic [1:0] OUT_ZERO = 2'd0;
  localparam logic [1:0] OUT_RUN  = 2'd1;
  localparam logic [1:0] OUT_DONE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       sample;
    logic       restart;
    logic       finish;
    logic       load_out;
    logic [1:0] out_kind;
  } sbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic measuring;
    logic conv_end;
    logic stop;
  } sbm_status_t;

endpackage

/* hdl/sbm_ctrl.sv */
// Controller state machine for the battery monitor sequencer.
// Depends on sbm_pkg; drives the datapath through sbm_cmd_t.
module sbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sbm_pkg::sbm_status_t status,
  output sbm_pkg::sbm_cmd_t    cmd
);
  import sbm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_MUL1   = 3'd2;
  localparam logic [2:0] S_MUL2   = 3'd3;
  localparam logic [2:0] S_MUL3   = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] kind, kind_next;
  logic       accept;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state, result kind and datapath commands.
  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.out_kind = kind;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_START) begin
            cmd.start  = 1'b1;
            kind_next  = OUT_RUN;
            state_next = S_EMIT;
          end else if (!status.measuring) begin
            kind_next  = OUT_ZERO;
            state_next = S_EMIT;
          end else begin
            cmd.sample = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.conv_end) begin
          state_next = S_MUL1;
        end else begin
          kind_next  = OUT_RUN;
          state_next = S_EMIT;
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_DECIDE;
      S_DECIDE: begin
        if (status.stop) begin
          cmd.finish = 1'b1;
          kind_next  = OUT_DONE;
        end else begin
          cmd.restart = 1'b1;
          kind_next   = OUT_RUN;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, result kind and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= OUT_ZERO;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/sbm_datapath.sv */
// Datapath of the battery monitor sequencer: configuration registers,
// search bounds, comparison counter, scaling pipeline and result register.
// Depends on sbm_pkg; controlled by sbm_ctrl through sbm_cmd_t.
module sbm_datapath #(
  parameter int THRESHOLD_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 above,
  input  logic                                 usb_present,
  input  sbm_pkg::sbm_cmd_t                    cmd,
  output sbm_pkg::sbm_status_t                 status,
  output logic [THRESHOLD_BITS-1:0]            threshold,
  output logic                                 divider_on,
  output logic                                 measurement_done,
  output logic [sbm_pkg::BAT_W-1:0]            battery_mv,
  output logic [1:0]                           supply_kind,
  output logic [sbm_pkg::COUNT_W-1:0]          comparisons_used
);
  import sbm_pkg::*;

  localparam logic [THRESHOLD_BITS-1:0] TH_MAX = '1;

  // Configuration registers.
  logic [MAXC_W-1:0]   max_comparisons;
  logic [MV_CFG_W-1:0] stop_mv;
  logic [REFSEL_W-1:0] reference_select;
  logic [MV_CFG_W-1:0] battery_min_mv;

  // Search state.
  logic [THRESHOLD_BITS-1:0] low_bound;
  logic [THRESHOLD_BITS-1:0] high_bound;
  logic [THRESHOLD_BITS-1:0] best_threshold;
  logic [COUNT_W-1:0]        comparison_count;
  logic                      measuring;
  logic                      usb_latched;

  // Scaling pipeline.
  logic [REF_W-1:0]                ref_mv;
  logic [REF_W+THRESHOLD_BITS-1:0] prod_ref;
  logic [SCALED_W-1:0]             prod_scale;
  logic [RECIP_PROD_W-1:0]         prod_recip;
  logic [BAT_W-1:0]                battery;

  logic [THRESHOLD_BITS:0]   mid_sum;
  logic [THRESHOLD_BITS-1:0] midpoint;
  logic [1:0]                source;

  // Midpoint of the current bounds, rounded up.
  assign mid_sum  = {1'b0, low_bound} + {1'b0, high_bound} + 1'b1;
  assign midpoint = mid_sum[THRESHOLD_BITS:1];

  // Reference voltage for the selected comparator reference.
  always_comb begin
    case (reference_select)
      REFSEL_1200: ref_mv = REF_MV_1200;
      REFSEL_1800: ref_mv = REF_MV_1800;
      REFSEL_2400: ref_mv = REF_MV_2400;
      default:     ref_mv = '0;
    endcase
  end

  // Supply classification from the latched USB flag and the battery level.
  always_comb begin
    if (usb_latched) begin
      source = ({2'b00, battery} < {2'b00, battery_min_mv}) ? SRC_USB : SRC_BOTH;
    end else begin
      source = ({2'b00, battery} >= {2'b00, battery_min_mv}) ? SRC_BATT : SRC_NONE;
    end
  end

  // Status towards the controller.
  assign status.measuring = measuring;
  assign status.conv_end  = !(high_bound > low_bound);
  assign status.stop      = (comparison_count >= {1'b0, max_comparisons}) ||
                            ((stop_mv != '0) && (battery >= stop_mv));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_comparisons  <= MAXC_RESET;
      stop_mv          <= STOP_RESET;
      reference_select <= REFSEL_RESET;
      battery_min_mv   <= BATMIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_COMPARISONS:  max_comparisons  <= cfg_data[MAXC_W-1:0];
        REG_STOP_MV:          stop_mv          <= cfg_data[MV_CFG_W-1:0];
        REG_REFERENCE_SELECT: reference_select <= cfg_data[REFSEL_W-1:0];
        REG_BATTERY_MIN_MV:   battery_min_mv   <= cfg_data[MV_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Binary search bounds, comparison counter and measurement flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound        <= '0;
      high_bound       <= TH_MAX;
      best_threshold   <= '0;
      comparison_count <= '0;
      measuring        <= 1'b0;
      usb_latched      <= 1'b0;
    end else begin
      if (cmd.start) begin
        usb_latched      <= usb_present;
        measuring        <= 1'b1;
        comparison_count <= '0;
        low_bound        <= '0;
        high_bound       <= TH_MAX;
        best_threshold   <= '0;
      end else if (cmd.sample) begin
        if (above) begin
          low_bound      <= midpoint;
          best_threshold <= midpoint;
        end else begin
          high_bound <= midpoint - 1'b1;
        end
        if (comparison_count != COUNT_MAX) begin
          comparison_count <= comparison_count + 1'b1;
        end
      end else if (cmd.restart) begin
        low_bound      <= '0;
        high_bound     <= TH_MAX;
        best_threshold <= '0;
      end else if (cmd.finish) begin
        measuring <= 1'b0;
      end
    end
  end

  // Scaling pipeline: ref * best, then * 4017, then the divide by 1000.
  always_ff @(posedge clk) begin
    prod_ref   <= ref_mv * best_threshold;
    prod_scale <= BATT_SCALE * prod_ref[THRESHOLD_BITS +: MV_W];
    prod_recip <= prod_scale * RECIP_1000;
    battery    <= prod_recip[RECIP_SHIFT +: BAT_W];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_kind)
        OUT_RUN: begin
          threshold        <= midpoint;
          divider_on       <= 1'b1;
          measurement_done <= 1'b0;
          battery_mv       <= '0;
          supply_kind      <= SRC_NONE;
          comparisons_used <= comparison_count;
        end
        OUT_DONE: begin
          threshold        <= '0;
          divider_on       <= 1'b0;
          measurement_done <= 1'b1;
          battery_mv       <= battery;
          supply_kind      <= source;
          comparisons_used <= comparison_count;
        end
        default: begin
          threshold        <= '0;
          divider_on       <= 1'b0;
          measurement_done <= 1'b0;
          battery_mv       <= '0;
          supply_kind      <= SRC_NONE;
          comparisons_used <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/sar_battery_monitor_sequencer_top.sv */
// Top level of the successive-approximation battery monitor sequencer.
// Depends on sbm_pkg, sbm_ctrl and sbm_datapath.
//
// Usage: an input item with action 0 starts a measurement, latches
// usb_present and returns the first comparator threshold with divider_on
// set. Each following item with action 1 carries the comparator output for
// that threshold and returns the next threshold, or, once the comparison
// budget is used up or the stop level is reached, a result with
// measurement_done, battery_mv and supply_kind. Comparator items while no
// measurement runs return an all-zero result. Every input item gives one
// result item.
// One item is handled at a time. After acceptance the controller goes to EMIT
// for a start or an ignored item, through CHECK to EMIT for a comparison inside
// a conversion and through CHECK, MUL1 to MUL3 and DECIDE, while the four-stage
// scaling pipeline fills, to EMIT for one that ends a conversion. out_valid and
// in_ready rise together as the result is loaded. A new item is accepted while
// the previous result still waits in the output register; a stalled receiver
// holds the block only when a second result is ready. Reset clears the search
// state and loads the register defaults. The user must write configuration
// through cfg_we only while no item is in flight; the block does not check it.
module sar_battery_monitor_sequencer_top #(
  parameter int THRESHOLD_BITS = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic                             above,
  input  logic                             usb_present,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [THRESHOLD_BITS-1:0]        threshold,
  output logic                             divider_on,
  output logic                             measurement_done,
  output logic [sbm_pkg::BAT_W-1:0]        battery_mv,
  output logic [1:0]                       supply_kind,
  output logic [sbm_pkg::COUNT_W-1:0]      comparisons_used
);
  import sbm_pkg::*;

  sbm_cmd_t    cmd;
  sbm_status_t status;

  // Sequencing of items and results.
  sbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Search, scaling and result registers.
  sbm_datapath #(
    .THRESHOLD_BITS (THRESHOLD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .above            (above),
    .usb_present      (usb_present),
    .cmd              (cmd),
    .status           (status),
    .threshold        (threshold),
    .divider_on       (divider_on),
    .measurement_done (measurement_done),
    .battery_mv       (battery_mv),
    .supply_kind      (supply_kind),
    .comparisons_used (comparisons_used)
  );

endmodule

/* verif/sbm_checker.sv */
`timescale 1ns / 1ps
// Checker for the battery monitor sequencer: follows register writes and both item channels,
// predicts every result item and compares it field by field. Depends on sbm_pkg.
module sbm_checker #(
  parameter int THRESHOLD_BITS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            action,
  input  logic                            above,
  input  logic                            usb_present,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [THRESHOLD_BITS-1:0]       threshold,
  input  logic                            divider_on,
  input  logic                            measurement_done,
  input  logic [sbm_pkg::BAT_W-1:0]       battery_mv,
  input  logic [1:0]                      supply_kind,
  input  logic [sbm_pkg::COUNT_W-1:0]     comparisons_used,
  output int                              error_count,
  output int                              pending_count,
  output int                              finished_count,
  output logic                            search_active
);
  import sbm_pkg::*;

  typedef struct packed {
    logic [THRESHOLD_BITS-1:0] threshold;
    logic                      divider_on;
    logic                      done;
    logic [BAT_W-1:0]          battery_mv;
    logic [1:0]                supply_kind;
    logic [COUNT_W-1:0]        comparisons_used;
  } reading_t;

  reading_t expected_readings[$];

  // Register copies.
  logic [MAXC_W-1:0]   budget;
  logic [MV_CFG_W-1:0] stop_level;
  logic [REFSEL_W-1:0] ref_sel;
  logic [MV_CFG_W-1:0] battery_floor;

  // Search state.
  logic [THRESHOLD_BITS-1:0] lo_code;
  logic [THRESHOLD_BITS-1:0] hi_code;
  logic [THRESHOLD_BITS-1:0] best_code;
  logic [COUNT_W-1:0]        cmp_count;
  logic                      usb_seen;

  // Midpoint of the current bounds, rounded up.
  function automatic logic [THRESHOLD_BITS-1:0] next_probe(
    input logic [THRESHOLD_BITS-1:0] lo,
    input logic [THRESHOLD_BITS-1:0] hi
  );
    logic [THRESHOLD_BITS:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
    return sum[THRESHOLD_BITS:1];
  endfunction

  // Converts the best code into compensated battery millivolts.
  function automatic logic [BAT_W-1:0] battery_reading(
    input logic [REFSEL_W-1:0]       sel,
    input logic [THRESHOLD_BITS-1:0] best
  );
    int unsigned ref_mv;
    int unsigned sense_mv;
    int unsigned bat;
    case (sel)
      REFSEL_1200: ref_mv = REF_MV_1200;
      REFSEL_1800: ref_mv = REF_MV_1800;
      REFSEL_2400: ref_mv = REF_MV_2400;
      default:     ref_mv = 0;
    endcase
    sense_mv = (ref_mv * best) >> THRESHOLD_BITS;
    bat = (BATT_SCALE * sense_mv) / 1000;
    return bat[BAT_W-1:0];
  endfunction

  task automatic restart_conversion();
    lo_code   = '0;
    hi_code   = '1;
    best_code = '0;
  endtask

  // Advances the search by one input item and works out the result it causes.
  task automatic advance_search(
    input  logic     act,
    input  logic     abv,
    input  logic     usb,
    output reading_t r
  );
    logic [THRESHOLD_BITS-1:0] probe;
    logic [BAT_W-1:0]          bat;
    r = '0;
    if (act == ACT_START) begin
      usb_seen      = usb;
      search_active = 1'b1;
      cmp_count     = '0;
      restart_conversion();
      r.threshold  = next_probe(lo_code, hi_code);
      r.divider_on = 1'b1;
    end else if (search_active) begin
      probe = next_probe(lo_code, hi_code);
      if (abv) begin
        lo_code   = probe;
        best_code = probe;
      end else begin
        hi_code = probe - 1'b1;
      end
      if (cmp_count != COUNT_MAX) cmp_count = cmp_count + 1'b1;
      r.comparisons_used = cmp_count;
      if (hi_code > lo_code) begin
        r.threshold  = next_probe(lo_code, hi_code);
        r.divider_on = 1'b1;
      end else begin
        bat = battery_reading(ref_sel, best_code);
        if (cmp_count >= {1'b0, budget} || (stop_level != '0 && bat >= stop_level)) begin
          // Measurement complete: report and classify the supply.
          search_active = 1'b0;
          r.done        = 1'b1;
          r.battery_mv  = bat;
          if (usb_seen) r.supply_kind = (bat < battery_floor) ? SRC_USB : SRC_BOTH;
          else          r.supply_kind = (bat >= battery_floor) ? SRC_BATT : SRC_NONE;
          finished_count++;
        end else begin
          restart_conversion();
          r.threshold  = next_probe(lo_code, hi_code);
          r.divider_on = 1'b1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  // Compares one accepted result item with the oldest expectation.
  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch("result item arrived with nothing expected");
      return;
    end
    want = expected_readings.pop_front();
    if (threshold !== want.threshold)
      report_mismatch($sformatf("threshold %0d, expected %0d", threshold, want.threshold));
    if (divider_on !== want.divider_on)
      report_mismatch($sformatf("divider_on %0b, expected %0b", divider_on, want.divider_on));
    if (measurement_done !== want.done)
      report_mismatch($sformatf("measurement_done %0b, expected %0b",
                                measurement_done, want.done));
    if (battery_mv !== want.battery_mv)
      report_mismatch($sformatf("battery_mv %0d, expected %0d", battery_mv, want.battery_mv));
    if (supply_kind !== want.supply_kind)
      report_mismatch($sformatf("supply_kind %0d, expected %0d",
                                supply_kind, want.supply_kind));
    if (comparisons_used !== want.comparisons_used)
      report_mismatch($sformatf("comparisons_used %0d, expected %0d",
                                comparisons_used, want.comparisons_used));
  endtask

  // Results are checked before the new item is predicted; a result always trails its item.
  always @(posedge clk) begin
    reading_t r;
    if (rst) begin
      budget        = MAXC_RESET;
      stop_level    = STOP_RESET;
      ref_sel       = REFSEL_RESET;
      battery_floor = BATMIN_RESET;
      restart_conversion();
      cmp_count      = '0;
      usb_seen       = 1'b0;
      search_active  = 1'b0;
      error_count    = 0;
      finished_count = 0;
      expected_readings.delete();
    end else begin
      if (out_valid && out_ready) check_reading();
      if (in_valid && in_ready) begin
        advance_search(action, above, usb_present, r);
        expected_readings.push_back(r);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_COMPARISONS:  budget        = cfg_data[MAXC_W-1:0];
          REG_STOP_MV:          stop_level    = cfg_data[MV_CFG_W-1:0];
          REG_REFERENCE_SELECT: ref_sel       = cfg_data[REFSEL_W-1:0];
          REG_BATTERY_MIN_MV:   battery_floor = cfg_data[MV_CFG_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count = expected_readings.size();
  end

endmodule

/* verif/tb_sar_battery_monitor_sequencer_top.sv */
`timescale 1ns / 1ps
// Testbench top for the battery monitor sequencer: clock, reset, register writes, item stimulus
// and result pacing, with the verdict. Depends on sbm_pkg, the block and sbm_checker.
module tb_sar_battery_monitor_sequencer_top;
  import sbm_pkg::*;

  localparam int TH_BITS         = 6;
  localparam int CLK_HALF_NS     = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_TARGET   = 650;
  localparam int SAMPLE_CAP      = 40;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_PHASE  = 2;

  typedef enum int {
    ABOVE_RANDOM,
    ABOVE_MOSTLY_HIGH,
    ABOVE_MOSTLY_LOW,
    ABOVE_ALL_HIGH,
    ABOVE_ALL_LOW
  } above_mode_e;

  typedef enum int {
    PACE_FREE,
    PACE_COIN,
    PACE_MOSTLY,
    PACE_PATTERN
  } pace_mode_e;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   action      = ACT_START;
  logic                   above       = 1'b0;
  logic                   usb_present = 1'b0;
  logic                   out_ready   = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [TH_BITS-1:0]     threshold;
  logic                   divider_on;
  logic                   measurement_done;
  logic [BAT_W-1:0]       battery_mv;
  logic [1:0]             supply_kind;
  logic [COUNT_W-1:0]     comparisons_used;

  int   error_count;
  int   pending_count;
  int   finished_count;
  logic search_active;

  logic hold_off_req   = 1'b0;
  int   burst_left     = 0;
  logic gaps_on        = 1'b1;
  int   items_sent     = 0;
  int   random_items   = 0;
  int   settings_count = 0;
  int   quiet_cycles   = 0;

  always #(CLK_HALF_NS) clk = ~clk;

  sar_battery_monitor_sequencer_top #(
    .THRESHOLD_BITS(TH_BITS)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .above            (above),
    .usb_present      (usb_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .threshold        (threshold),
    .divider_on       (divider_on),
    .measurement_done (measurement_done),
    .battery_mv       (battery_mv),
    .supply_kind      (supply_kind),
    .comparisons_used (comparisons_used)
  );

  sbm_checker #(
    .THRESHOLD_BITS(TH_BITS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .above            (above),
    .usb_present      (usb_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .threshold        (threshold),
    .divider_on       (divider_on),
    .measurement_done (measurement_done),
    .battery_mv       (battery_mv),
    .supply_kind      (supply_kind),
    .comparisons_used (comparisons_used),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .finished_count   (finished_count),
    .search_active    (search_active)
  );

  // Watchdog: ends the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side pacing, with a long hold-off on request.
  initial begin : result_pacing
    int         hold_left;
    int         mode_left;
    int         tick;
    pace_mode_e mode;
    hold_left = 0;
    mode_left = 0;
    tick      = 0;
    mode      = PACE_FREE;
    forever begin
      @(negedge clk);
      tick++;
      if (mode_left == 0) begin
        mode      = pace_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          PACE_FREE:   out_ready <= 1'b1;
          PACE_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          PACE_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:     out_ready <= ((tick % 7) > 2);
        endcase
      end
    end
  end

  function automatic logic coin();
    return ($urandom_range(0, 1) == 1);
  endfunction

  function automatic logic pick_above(input above_mode_e m);
    case (m)
      ABOVE_MOSTLY_HIGH: return ($urandom_range(0, 9) != 0);
      ABOVE_MOSTLY_LOW:  return ($urandom_range(0, 9) == 0);
      ABOVE_ALL_HIGH:    return 1'b1;
      ABOVE_ALL_LOW:     return 1'b0;
      default:           return coin();
    endcase
  endfunction

  // Offers one item, starting and ending at a falling edge. Items go out in bursts with
  // random gaps between them; valid stays up between items of a burst.
  task automatic send_item(input logic act, input logic abv, input logic usb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    action      <= act;
    above       <= abv;
    usb_present <= usb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers on consecutive cycles.
  task automatic write_settings(
    input logic [CFG_DATA_W-1:0] maxc,
    input logic [CFG_DATA_W-1:0] stop,
    input logic [CFG_DATA_W-1:0] sel,
    input logic [CFG_DATA_W-1:0] floor_mv
  );
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_COMPARISONS;
    cfg_data  <= maxc;
    @(negedge clk);
    cfg_index <= REG_STOP_MV;
    cfg_data  <= stop;
    @(negedge clk);
    cfg_index <= REG_REFERENCE_SELECT;
    cfg_data  <= sel;
    @(negedge clk);
    cfg_index <= REG_BATTERY_MIN_MV;
    cfg_data  <= floor_mv;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // One well-formed measurement with random content and the odd restart or stray item.
  task automatic run_measurement(input above_mode_e m);
    int samples;
    samples = 0;
    send_item(ACT_START, coin(), coin());
    random_items++;
    while (search_active && samples < SAMPLE_CAP) begin
      if ($urandom_range(0, 99) < 2) send_item(ACT_START, coin(), coin());
      else send_item(ACT_SAMPLE, pick_above(m), coin());
      random_items++;
      samples++;
    end
    if ($urandom_range(0, 3) == 0) send_item(ACT_SAMPLE, coin(), coin());
  endtask

  initial begin : stimulus
    int          phase;
    int          runs;
    int          maxc;
    int          stop;
    int          sel;
    int          floor_mv;
    above_mode_e mode;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: comparator items while idle are ignored.
    send_item(ACT_SAMPLE, 1'b0, 1'b0);
    send_item(ACT_SAMPLE, 1'b1, 1'b1);
    // Full scale on the lowest reference stops after one conversion, USB and battery.
    send_item(ACT_START, 1'b0, 1'b1);
    repeat (6) send_item(ACT_SAMPLE, 1'b1, 1'b0);
    send_item(ACT_SAMPLE, 1'b0, 1'b1);
    // A start in the middle of a measurement begins it again from scratch.
    send_item(ACT_START, 1'b1, 1'b0);
    repeat (2) send_item(ACT_SAMPLE, 1'b0, 1'b1);
    send_item(ACT_START, 1'b0, 1'b0);
    repeat (6) send_item(ACT_SAMPLE, 1'b1, 1'b1);
    drain();

    // Zero budget, stop level disabled and the unused reference selector.
    write_settings(0, 0, 3, 16383);
    send_item(ACT_START, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_item(ACT_SAMPLE, (i % 2) == 1, 1'b0);
    drain();

    // Random measurements over a series of register settings.
    phase = 0;
    while (random_items < RANDOM_TARGET) begin
      case (phase)
        0: begin
          maxc = 4095; stop = 1; sel = REFSEL_2400; floor_mv = 0;
        end
        1: begin
          maxc = 1; stop = 16383; sel = REFSEL_2400; floor_mv = 16383;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       maxc = 0;
            1:       maxc = 1;
            2:       maxc = 4095;
            default: maxc = $urandom_range(2, 30);
          endcase
          case ($urandom_range(0, 5))
            0:       stop = 0;
            1:       stop = 16383;
            2:       stop = 1;
            default: stop = $urandom_range(0, 16383);
          endcase
          case ($urandom_range(0, 4))
            0:       floor_mv = 0;
            1:       floor_mv = 16383;
            default: floor_mv = $urandom_range(0, 9500);
          endcase
          sel = $urandom_range(0, 3);
          // A large budget needs a stop level that a conversion can reach.
          if (maxc > 60) begin
            if (sel == 3) sel = $urandom_range(0, 2);
            if (stop == 0 || stop > 4000) stop = $urandom_range(1, 4000);
          end
        end
      endcase
      drain();
      write_settings(maxc, stop, sel, floor_mv);
      gaps_on = ($urandom_range(0, 3) != 0);
      mode = above_mode_e'($urandom_range(0, 4));
      if (phase == HOLD_OFF_PHASE) hold_off_req = 1'b1;
      runs = $urandom_range(3, 8);
      for (int k = 0; k < runs && random_items < RANDOM_TARGET; k++) run_measurement(mode);
      phase++;
    end
    drain();

    $display("Run covered %0d input items, %0d of them in random measurements, over %0d settings.",
             items_sent, random_items, settings_count);
    $display("%0d measurements ran to completion and were checked.", finished_count);
    if (pending_count != 0) $display("ERROR: %0d result items never arrived", pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
